[hdl/lspq_pkg.sv]
`default_nettype none

package lspq_pkg;

  localparam int unsigned DepthDefault = 128;

  typedef enum logic {
    FN_ENQ = 1'b0,
    FN_DEQ = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    func_e              func;
    logic signed [31:0] item_value;
    logic signed [31:0] item_rank;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    status_e            status;
    logic [7:0]         held_count;
  } out_word_t;

  // one stored entry: value in the upper half, rank in the lower
  typedef struct packed {
    logic signed [31:0] value;
    logic signed [31:0] rank;
  } entry_t;

endpackage

`default_nettype wire

[hdl/lspq_ram.sv]
`default_nettype none

module lspq_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(Depth)-1:0] wr_addr_i,
  input  wire logic [Width-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic      [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

[hdl/linear_scan_priority_queue.sv]
// Bounded priority queue held unsorted in arrival order in one RAM.
// Input words carry func (enqueue or dequeue), item_value and item_rank;
// output words carry out_value, status and held_count. Both channels use
// valid/stall: a word moves at a clock edge with valid high and stall low.
// Exactly one output word follows each input word, in order.
// Enqueue: appends at the tail, or reports full; its result is registered.
// Dequeue of N held entries: the RAM read port scans all N entries, one
// per cycle, keeping the earliest greatest rank, then moves every later
// entry down one place, again one read a cycle. Empty dequeue returns -1.
// One word is worked on at a time; in_stall_o is high
// until its result has been handed to the output register.
// The output register holds a finished word while the receiver stalls; a
// new word is accepted meanwhile and its result waits inside the block.
// Reset empties the queue and clears the output; RAM contents are not
// cleared, as only entries below the count are ever read.
`default_nettype none

module linear_scan_priority_queue #(
  parameter int unsigned DEPTH = lspq_pkg::DepthDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire lspq_pkg::in_word_t in_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output lspq_pkg::out_word_t     out_word_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_EMIT  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] iss_q, iss_d;
  logic          rvld_q, rvld_d;
  logic [AW-1:0] ridx_q, ridx_d;

  logic [AW-1:0]      best_idx_q, best_idx_d;
  logic signed [31:0] best_rank_q, best_rank_d;
  logic signed [31:0] best_val_q, best_val_d;

  lspq_pkg::out_word_t res_q, res_d;
  lspq_pkg::out_word_t out_q, out_d;
  logic                out_vld_q, out_vld_d;

  logic             wr_en, rd_en;
  logic [AW-1:0]    wr_addr, rd_addr;
  lspq_pkg::entry_t wr_data, rd_data;

  logic in_acc;
  logic out_load;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == S_EMIT) && (!out_vld_q || !out_stall_i);

  lspq_ram #(
    .Width ($bits(lspq_pkg::entry_t)),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    iss_d       = iss_q;
    rvld_d      = 1'b0;
    ridx_d      = ridx_q;
    best_idx_d  = best_idx_q;
    best_rank_d = best_rank_q;
    best_val_d  = best_val_q;
    res_d       = res_q;
    wr_en       = 1'b0;
    wr_addr     = cnt_q[AW-1:0];
    wr_data     = '{value: in_word_i.item_value, rank: in_word_i.item_rank};
    rd_en       = 1'b0;
    rd_addr     = iss_q[AW-1:0];

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_EMIT;
          if (in_word_i.func == lspq_pkg::FN_ENQ) begin
            if (cnt_q == CW'(DEPTH)) begin
              res_d = '{out_value: '0, status: lspq_pkg::ST_FULL,
                        held_count: 8'(cnt_q)};
            end else begin
              wr_en = 1'b1;
              cnt_d = cnt_q + CW'(1);
              res_d = '{out_value: '0, status: lspq_pkg::ST_OK,
                        held_count: 8'(cnt_q + CW'(1))};
            end
          end else if (cnt_q == '0) begin
            res_d = '{out_value: '1, status: lspq_pkg::ST_EMPTY,
                      held_count: 8'(cnt_q)};
          end else begin
            iss_d   = '0;
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (iss_q < cnt_q) begin
          rd_en  = 1'b1;
          iss_d  = iss_q + CW'(1);
          rvld_d = 1'b1;
          ridx_d = iss_q[AW-1:0];
        end
        if (rvld_q) begin
          // first entry is taken outright; later ones only on a strictly
          // greater rank, so ties keep the earliest
          if (ridx_q == '0 || rd_data.rank > best_rank_q) begin
            best_idx_d  = ridx_q;
            best_rank_d = rd_data.rank;
            best_val_d  = rd_data.value;
          end
        end else if (iss_q == cnt_q) begin
          iss_d   = CW'(best_idx_q) + CW'(1);
          state_d = S_SHIFT;
        end
      end

      S_SHIFT: begin
        if (iss_q < cnt_q) begin
          rd_en  = 1'b1;
          iss_d  = iss_q + CW'(1);
          rvld_d = 1'b1;
          ridx_d = iss_q[AW-1:0];
        end
        if (rvld_q) begin
          // write lags the read by one place, never the same entry
          wr_en   = 1'b1;
          wr_addr = ridx_q - AW'(1);
          wr_data = rd_data;
        end else if (iss_q >= cnt_q) begin
          cnt_d   = cnt_q - CW'(1);
          res_d   = '{out_value: best_val_q, status: lspq_pkg::ST_OK,
                      held_count: 8'(cnt_q - CW'(1))};
          state_d = S_EMIT;
        end
      end

      S_EMIT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_d     = out_q;
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_d     = res_q;
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      rvld_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rvld_q    <= rvld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    iss_q       <= iss_d;
    ridx_q      <= ridx_d;
    best_idx_q  <= best_idx_d;
    best_rank_q <= best_rank_d;
    best_val_q  <= best_val_d;
    res_q       <= res_d;
    out_q       <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire

[hdl/lspq_checker.sv]
`default_nettype none

module lspq_checker #(
  parameter int unsigned DEPTH = lspq_pkg::DepthDefault
) (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire lspq_pkg::in_word_t  in_word_i,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire lspq_pkg::out_word_t out_word_o
);

  // a stalled output word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word changed while stalled");

  // every accepted word makes the block busy, raising in_stall_o
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken on consecutive cycles");

  a_empty_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status == lspq_pkg::ST_EMPTY |->
      out_word_o.out_value == -32'sd1 && out_word_o.held_count == 8'd0)
    else $error("empty result malformed");

  a_full_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status == lspq_pkg::ST_FULL |->
      out_word_o.out_value == 32'sd0 && out_word_o.held_count == 8'(DEPTH))
    else $error("full result malformed");

endmodule

bind linear_scan_priority_queue lspq_checker #(
  .DEPTH (DEPTH)
) u_lspq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);

`default_nettype wire

[tb/sv/tb_linear_scan_priority_queue.sv]
module tb_linear_scan_priority_queue;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth         = lspq_pkg::DepthDefault;
  localparam int          TotalWords    = 1470;
  localparam int          QuietWords    = 150;
  localparam int          HoldCycles    = 400;
  localparam int          SettleCycles  = 2 * Depth + 40;
  localparam int          WatchdogLimit = 20000;

  // shadow copy of the queue; predicts one output word per accepted input word
  class queue_shadow;
    logic signed [31:0]  val_mem  [Depth];
    logic signed [31:0]  rank_mem [Depth];
    int unsigned         held;
    lspq_pkg::out_word_t due_q [$];
    int unsigned         mismatches;

    function new();
      held       = 0;
      mismatches = 0;
    endfunction

    function void accept_word(lspq_pkg::in_word_t w);
      lspq_pkg::out_word_t r;
      int unsigned         best;
      int unsigned         i;
      r.out_value = '0;
      r.status    = lspq_pkg::ST_OK;
      if (w.func == lspq_pkg::FN_ENQ) begin
        if (held >= Depth) begin
          r.status = lspq_pkg::ST_FULL;
        end else begin
          val_mem[held]  = w.item_value;
          rank_mem[held] = w.item_rank;
          held++;
        end
      end else if (held == 0) begin
        r.out_value = -32'sd1;
        r.status    = lspq_pkg::ST_EMPTY;
      end else begin
        // strict compare keeps the earliest of equal ranks
        best = 0;
        for (i = 1; i < held; i++) begin
          if (rank_mem[i] > rank_mem[best]) best = i;
        end
        r.out_value = val_mem[best];
        for (i = best; i + 1 < held; i++) begin
          val_mem[i]  = val_mem[i + 1];
          rank_mem[i] = rank_mem[i + 1];
        end
        held--;
      end
      r.held_count = held[7:0];
      due_q.push_back(r);
    endfunction

    function void check_word(lspq_pkg::out_word_t got);
      lspq_pkg::out_word_t exp_w;
      if (due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected output word %h", $realtime, got);
        return;
      end
      exp_w = due_q.pop_front();
      if (got.out_value !== exp_w.out_value || got.status !== exp_w.status ||
          got.held_count !== exp_w.held_count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch: value %h/%h, status %0d/%0d, count %0d/%0d (exp/got)",
                   $realtime, exp_w.out_value, got.out_value, exp_w.status, got.status,
                   exp_w.held_count, got.held_count);
      end
    endfunction

    function int unsigned pending();
      return due_q.size();
    endfunction
  endclass

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  lspq_pkg::in_word_t  in_word   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  lspq_pkg::out_word_t out_word;

  bit          quiet    = 1'b0;
  bit          hold_req = 1'b0;
  int          idle_cycles = 0;
  int          sent = 0;
  queue_shadow book;

  always #1 clk = ~clk;

  linear_scan_priority_queue DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  // result side: check accepted words, watchdog on cycles with no movement
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) book.check_word(out_word);
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
        $display("tb_linear_scan_priority_queue: FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // receiver stall pattern, plus one long hold-off on request
  initial begin : rx_side
    int n;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      n = $urandom_range(1, 19);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  task automatic put_word(input lspq_pkg::in_word_t w);
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    book.accept_word(w);
    sent++;
    if (!quiet && !hold_req && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic enq(input logic signed [31:0] v, input logic signed [31:0] r);
    lspq_pkg::in_word_t w;
    w.func       = lspq_pkg::FN_ENQ;
    w.item_value = v;
    w.item_rank  = r;
    put_word(w);
  endtask

  task automatic deq();
    lspq_pkg::in_word_t w;
    w.func       = lspq_pkg::FN_DEQ;
    w.item_value = $urandom;
    w.item_rank  = $urandom;
    put_word(w);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_rank();
    case ($urandom_range(0, 5))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return $signed($urandom_range(0, 7)) - 4;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  initial begin : stimulus
    int mode;
    int len;
    int pct;
    int k;
    bit first_phase;
    bit hold_done;
    bit pause_done;
    book        = new();
    first_phase = 1'b1;
    hold_done   = 1'b0;
    pause_done  = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // empty queue, then ties at the most negative rank
    deq();
    enq(32'sh7fff_ffff, 32'sh8000_0000);
    enq(32'sh8000_0000, 32'sh8000_0000);
    enq(32'sh0000_0000, 32'sh8000_0000);
    repeat (3) deq();
    deq();
    // ties at the top rank, mixed signs, alternating bit patterns
    enq(-32'sd1, 32'sh7fff_ffff);
    enq(32'sd1, 32'sd0);
    enq(32'sd2, -32'sd1);
    enq(32'sd3, 32'sh7fff_ffff);
    enq(32'sh5555_5555, 32'shaaaa_aaaa);
    enq(32'shaaaa_aaaa, 32'sh5555_5555);
    repeat (6) deq();
    deq();

    // random phases; the first fills past capacity to hit the full case
    while (sent < TotalWords) begin
      if (first_phase) begin
        mode = 0;
        len  = 170;
        first_phase = 1'b0;
      end else begin
        mode = $urandom_range(0, 2);
        len  = $urandom_range(30, 160);
      end
      pct = (mode == 0) ? 94 : (mode == 1) ? 8 : 55;
      for (k = 0; k < len && sent < TotalWords; k++) begin
        if (!hold_done && sent >= 500) begin
          hold_req  = 1'b1;
          hold_done = 1'b1;
        end
        if (!pause_done && sent >= 900) begin
          wait_drained();
          pause_done = 1'b1;
        end
        quiet = (sent >= TotalWords - QuietWords);
        if ($urandom_range(0, 99) < pct) enq(rand_value(), rand_rank());
        else deq();
      end
    end

    wait_drained();
    repeat (SettleCycles) @(posedge clk);
    if (book.mismatches == 0 && book.pending() == 0) begin
      $display("tb_linear_scan_priority_queue: PASS");
    end else begin
      $display("tb_linear_scan_priority_queue: FAIL");
    end
    $finish;
  end

endmodule

[linear_scan_priority_queue.f]
hdl/lspq_pkg.sv
hdl/lspq_ram.sv
hdl/linear_scan_priority_queue.sv
hdl/lspq_checker.sv
tb/sv/tb_linear_scan_priority_queue.sv
